// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RDSL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define RDSL_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/rdsl_pkg.sv
// Types, constants and arithmetic helpers of the radial density spline lookup.
`timescale 1ns / 1ps
`default_nettype none
package rdsl_pkg;

    localparam logic signed [63:0] SAT_INT = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        SAT_U   = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT_W   = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] DEN_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] DEN_MIN = -64'sh0000_8000_0000_0000;

    localparam int DIV_STEPS = 96;
    localparam int PROG_LEN  = 38;
    localparam int PC_W      = 6;
    localparam int RF_DEPTH  = 14;

    typedef enum logic [1:0] {
        CMD_WR_RADIUS,
        CMD_WR_WAVE,
        CMD_SET_LEN,
        CMD_QUERY
    } t_cmd;

    typedef enum logic [1:0] {
        RGN_INSIDE,
        RGN_BELOW,
        RGN_BEYOND,
        RGN_SHORT
    } t_region;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_DIV,
        AS_FIN,
        AS_DONE
    } t_alu_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A0,
        S_A1,
        S_A2,
        S_SRCH,
        S_SCMP,
        S_FADDR,
        S_FCAPT,
        S_LOAD,
        S_EXRD,
        S_EXGO,
        S_EXWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
    } t_alu_rsp;

    // scratch register file slots
    localparam logic [3:0] RF_F1 = 4'd0;
    localparam logic [3:0] RF_F2 = 4'd1;
    localparam logic [3:0] RF_F3 = 4'd2;
    localparam logic [3:0] RF_F4 = 4'd3;
    localparam logic [3:0] RF_H1 = 4'd4;
    localparam logic [3:0] RF_H2 = 4'd5;
    localparam logic [3:0] RF_H3 = 4'd6;
    localparam logic [3:0] RF_D1 = 4'd7;
    localparam logic [3:0] RF_D2 = 4'd8;
    localparam logic [3:0] RF_T0 = 4'd9;
    localparam logic [3:0] RF_T1 = 4'd10;
    localparam logic [3:0] RF_T2 = 4'd11;
    localparam logic [3:0] RF_T3 = 4'd12;
    localparam logic [3:0] RF_T4 = 4'd13;

    typedef struct packed {
        t_alu_op    op;
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
    } t_step;

    // Hermite evaluation; the last step leaves the density in T0.
    localparam t_step PROG [PROG_LEN] = '{
        '{ALU_SUB, RF_T0, RF_F3, RF_F2},
        '{ALU_SUB, RF_T1, RF_F2, RF_F1},
        '{ALU_DIV, RF_T2, RF_H1, RF_H2},
        '{ALU_MUL, RF_T2, RF_T0, RF_T2},
        '{ALU_DIV, RF_T3, RF_H2, RF_H1},
        '{ALU_MUL, RF_T3, RF_T1, RF_T3},
        '{ALU_ADD, RF_T2, RF_T2, RF_T3},
        '{ALU_ADD, RF_T3, RF_H1, RF_H2},
        '{ALU_DIV, RF_T3, RF_H2, RF_T3},
        '{ALU_MUL, RF_T2, RF_T2, RF_T3},
        '{ALU_SUB, RF_T1, RF_F4, RF_F3},
        '{ALU_DIV, RF_T3, RF_H2, RF_H3},
        '{ALU_MUL, RF_T1, RF_T1, RF_T3},
        '{ALU_DIV, RF_T3, RF_H3, RF_H2},
        '{ALU_MUL, RF_T3, RF_T0, RF_T3},
        '{ALU_ADD, RF_T1, RF_T1, RF_T3},
        '{ALU_ADD, RF_T3, RF_H2, RF_H3},
        '{ALU_DIV, RF_T3, RF_H2, RF_T3},
        '{ALU_MUL, RF_T1, RF_T1, RF_T3},
        '{ALU_DIV, RF_D1, RF_D1, RF_H2},
        '{ALU_DIV, RF_D2, RF_D2, RF_H2},
        '{ALU_ADD, RF_T0, RF_F2, RF_F2},
        '{ALU_ADD, RF_T3, RF_T0, RF_F2},
        '{ALU_ADD, RF_T0, RF_T0, RF_T2},
        '{ALU_MUL, RF_T0, RF_T0, RF_D2},
        '{ALU_ADD, RF_T3, RF_T3, RF_T2},
        '{ALU_ADD, RF_T3, RF_T3, RF_T0},
        '{ALU_ADD, RF_T0, RF_F3, RF_F3},
        '{ALU_ADD, RF_T4, RF_T0, RF_F3},
        '{ALU_SUB, RF_T0, RF_T0, RF_T1},
        '{ALU_MUL, RF_T0, RF_T0, RF_D1},
        '{ALU_SUB, RF_T4, RF_T4, RF_T1},
        '{ALU_SUB, RF_T4, RF_T4, RF_T0},
        '{ALU_MUL, RF_T0, RF_D2, RF_D2},
        '{ALU_MUL, RF_T0, RF_T0, RF_T3},
        '{ALU_MUL, RF_T1, RF_D1, RF_D1},
        '{ALU_MUL, RF_T1, RF_T1, RF_T4},
        '{ALU_ADD, RF_T0, RF_T0, RF_T1}
    };

    function automatic logic signed [63:0] sat_w(input logic signed [64:0] v);
        if (v > SAT_W) return SAT_INT;
        if (v < -SAT_W) return -SAT_INT;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sa;
        logic signed [64:0] sb;
        sa = 65'(sat_w({a[63], a}));
        sb = 65'(sat_w({b[63], b}));
        return sat_w(sa + sb);
    endfunction

    function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sa;
        logic signed [64:0] sb;
        sa = 65'(sat_w({a[63], a}));
        sb = 65'(sat_w({b[63], b}));
        return sat_w(sa - sb);
    endfunction

    function automatic logic [63:0] magn64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Q8.24 wave value squared, rounded half up to Q16.32
    function automatic logic signed [63:0] sq_q32(input logic [31:0] w);
        logic [31:0] m;
        logic [63:0] p;
        m = w[31] ? (~w + 32'd1) : w;
        p = m * m;
        return (p + 64'd32768) >> 16;
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        if (v > DEN_MAX) return DEN_MAX[47:0];
        if (v < DEN_MIN) return DEN_MIN[47:0];
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] udiff(input logic [31:0] a, input logic [31:0] b);
        return $signed({32'b0, a}) - $signed({32'b0, b});
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rdsl_alu.sv
// Multi-cycle saturating Q.32 arithmetic unit: add, subtract, multiply, divide.
`timescale 1ns / 1ps
`default_nettype none
module rdsl_alu
    import rdsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_alu_req           i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output t_alu_rsp           o_rsp
);

    t_alu_state         r_state;
    t_alu_state         n_state;
    t_alu_op            r_op;
    logic               r_neg;
    logic [63:0]        r_x;
    logic [63:0]        r_y;
    logic [127:0]       r_acc;
    logic [6:0]         r_cnt;
    logic [63:0]        r_d;
    logic [95:0]        r_num;
    logic [63:0]        r_rem;
    logic [95:0]        r_quo;
    logic signed [63:0] r_res;

    logic [31:0]  xp;
    logic [31:0]  yp;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  rem_sh;
    logic         ge;
    logic [64:0]  rem_nx;
    logic [127:0] rnd;
    logic [63:0]  mul_mag;
    logic [63:0]  div_q;
    logic [63:0]  div_mag;
    logic [63:0]  fin_mag;

    // one 32x32 partial product a cycle
    assign xp = r_cnt[0] ? r_x[63:32] : r_x[31:0];
    assign yp = r_cnt[1] ? r_y[63:32] : r_y[31:0];
    assign pp = xp * yp;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    // restoring division, one quotient bit a cycle
    assign rem_sh = {r_rem, r_num[95]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_d}) : rem_sh;

    assign rnd     = r_acc + 128'h8000_0000;
    assign mul_mag = (rnd[127:32] > {32'b0, SAT_U}) ? SAT_U : rnd[95:32];
    assign div_q   = r_quo[63:0] + ((r_rem >= (r_d - r_rem)) ? 64'd1 : 64'd0);

    always_comb begin
        if (r_d == 64'd0) begin
            div_mag = 64'd0;
        end else if (r_quo > {32'b0, SAT_U}) begin
            div_mag = SAT_U;
        end else if (div_q > SAT_U) begin
            div_mag = SAT_U;
        end else begin
            div_mag = div_q;
        end
    end

    assign fin_mag = (r_op == ALU_MUL) ? mul_mag : div_mag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        ALU_MUL: n_state = AS_MUL;
                        ALU_DIV: n_state = AS_DIV;
                        default: n_state = AS_DONE;
                    endcase
                end
            end
            AS_MUL:  if (r_cnt == 7'd3) n_state = AS_FIN;
            AS_DIV:  if (r_cnt == 7'(DIV_STEPS - 1)) n_state = AS_FIN;
            AS_FIN:  n_state = AS_DONE;
            AS_DONE: n_state = AS_IDLE;
            default: n_state = AS_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == AS_DONE);
        o_rsp.value = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_neg <= i_a[63] ^ i_b[63];
                    r_cnt <= '0;
                    r_x   <= magn64(i_a);
                    r_y   <= magn64(i_b);
                    r_acc <= '0;
                    r_d   <= magn64(i_b);
                    r_num <= {magn64(i_a), 32'b0};
                    r_rem <= '0;
                    r_quo <= '0;
                    if (i_req.op == ALU_ADD) r_res <= add_sat(i_a, i_b);
                    if (i_req.op == ALU_SUB) r_res <= sub_sat(i_a, i_b);
                end
            end
            AS_MUL: begin
                r_acc <= r_acc + pp_sh;
                r_cnt <= r_cnt + 7'd1;
            end
            AS_DIV: begin
                r_rem <= rem_nx[63:0];
                r_num <= {r_num[94:0], 1'b0};
                r_quo <= {r_quo[94:0], ge};
                r_cnt <= r_cnt + 7'd1;
            end
            AS_FIN: begin
                r_res <= r_neg ? $signed(~fin_mag + 64'd1) : $signed(fin_mag);
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/radial_density_spline_lookup_unit.sv
// Top level of the radial density spline lookup: mesh tables, search and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel (i_valid / o_ready) carries commands: write mesh radius, write
//   wave value, set mesh length, query. Output channel (o_valid / i_ready)
//   returns one density/region transaction per query; writes return nothing.
//   o_ready is high only while the unit is idle; one command is in work at a time.
// Query flow
//   A write completes on acceptance and the unit stays idle. A query that ends
//   early (short mesh, bad selector) goes straight to S_OUT; below the mesh it
//   answers from S_A1 and beyond it from S_A2. A query inside the mesh runs the
//   binary search (S_SRCH/S_SCMP), the four-point fetch (S_FADDR/S_FCAPT), the
//   loads (S_LOAD) and the Hermite program: 8 divisions on the one-bit-per-cycle
//   divider, 12 multiplies and 18 add/subtracts. The divisions take the most time.
// Reset
//   Synchronous, active low: the control returns to idle, the output register
//   empties and all mesh lengths clear to zero. Radius and wave tables keep their
//   contents and read as garbage until written.
// Stall
//   A finished result moves into the output register and waits there for i_ready
//   while the unit goes back to idle; a later query holds its result in the last
//   state until the output register frees.
module radial_density_spline_lookup_unit
    import rdsl_pkg::*;
#(
    parameter int NUM_SPECIES = 4,
    parameter int MESH_MAX    = 1024,
    parameter int ANG_MAX     = 4,
    parameter int MUL_MAX     = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [1:0]         i_species,
    input  logic [1:0]         i_ang_index,
    input  logic               i_multiplicity,
    input  logic [9:0]         i_point_index,
    input  logic signed [31:0] i_table_value,
    input  logic [10:0]        i_mesh_count,
    input  logic [31:0]        i_radius,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [47:0] o_density,
    output logic [1:0]         o_region
);

    localparam int MI_W       = $clog2(MESH_MAX);
    localparam int LEN_W      = $clog2(MESH_MAX + 1);
    localparam int SP_W       = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
    localparam int RAD_DEPTH  = NUM_SPECIES * MESH_MAX;
    localparam int RA_W       = $clog2(RAD_DEPTH);
    localparam int WAVE_DEPTH = NUM_SPECIES * ANG_MAX * MUL_MAX * MESH_MAX;
    localparam int WA_W       = $clog2(WAVE_DEPTH);

    // state and query context
    t_state              r_state;
    t_state              n_state;
    logic [1:0]          r_sp;
    logic [1:0]          r_ang;
    logic                r_mul;
    logic [31:0]         r_rq;
    logic [LEN_W-1:0]    r_len;
    logic [MI_W-1:0]     r_lo;
    logic [MI_W-1:0]     r_hi;
    logic [MI_W-1:0]     r_mid;
    logic [MI_W-1:0]     r_m;
    logic [1:0]          r_k;
    logic [2:0]          r_j;
    logic [PC_W-1:0]     r_pc;
    logic [31:0]         r_tap [4];
    logic signed [47:0]  r_dens;
    t_region             r_region;
    logic [LEN_W-1:0]    r_lengths [NUM_SPECIES];

    // output register
    logic                r_out_valid;
    logic signed [47:0]  r_out_dens;
    t_region             r_out_region;
    logic                out_load;

    // memories
    logic [31:0]         rad_mem  [RAD_DEPTH];
    logic [31:0]         wave_mem [WAVE_DEPTH];
    logic signed [63:0]  rf_mem   [RF_DEPTH];
    logic [31:0]         r_rad_rd;
    logic [31:0]         r_wave_rd;
    logic signed [63:0]  r_rf_a;
    logic signed [63:0]  r_rf_b;

    logic                acc_in;
    t_cmd                cmd;
    logic                sp_ok;
    logic                sel_ok;
    logic                pt_ok;
    logic [LEN_W-1:0]    len_sel;
    logic                short_mesh;
    logic [MI_W:0]       sum_lh;
    logic [MI_W-1:0]     mid;
    logic                last_pt;
    logic [MI_W-1:0]     fetch_idx;
    logic [MI_W-1:0]     rd_idx;
    logic [RA_W-1:0]     rad_ra;
    logic [RA_W-1:0]     rad_wa;
    logic [WA_W-1:0]     wave_ra;
    logic [WA_W-1:0]     wave_wa;
    logic                rad_we;
    logic                wave_we;
    logic                len_we;
    logic [LEN_W-1:0]    len_wd;
    logic signed [63:0]  load_val;
    logic                rf_we;
    logic [3:0]          rf_wa;
    logic signed [63:0]  rf_wd;
    t_step               step;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    assign acc_in = i_valid && o_ready;
    assign cmd    = t_cmd'(i_command);
    assign step   = PROG[r_pc];

    // hand the finished result to the output register once it is free
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // selector checks on the incoming command
    assign sp_ok  = 32'(i_species) < NUM_SPECIES;
    assign sel_ok = sp_ok && (32'(i_ang_index) < ANG_MAX) && (32'(i_multiplicity) < MUL_MAX);
    assign pt_ok  = 32'(i_point_index) < MESH_MAX;

    assign len_sel    = sp_ok ? r_lengths[SP_W'(i_species)] : '0;
    assign short_mesh = !sel_ok || (len_sel < LEN_W'(4));
    assign len_wd     = (int'(i_mesh_count) > MESH_MAX) ? LEN_W'(MESH_MAX)
                                                        : LEN_W'(i_mesh_count);

    // table writes land straight from the input port
    always_comb begin
        rad_we  = 1'b0;
        wave_we = 1'b0;
        len_we  = 1'b0;
        if (r_state == S_IDLE && acc_in) begin
            unique case (cmd)
                CMD_WR_RADIUS: rad_we  = sp_ok && pt_ok;
                CMD_WR_WAVE:   wave_we = sel_ok && pt_ok;
                CMD_SET_LEN:   len_we  = sp_ok;
                CMD_QUERY:     ;
            endcase
        end
    end

    assign rad_wa  = RA_W'(int'(i_species) * MESH_MAX + int'(i_point_index));
    assign wave_wa = WA_W'(((int'(i_species) * ANG_MAX + int'(i_ang_index)) * MUL_MAX
                            + int'(i_multiplicity)) * MESH_MAX + int'(i_point_index));

    // binary search midpoint and the four-point fetch window
    assign sum_lh  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = sum_lh[MI_W:1];
    assign last_pt = (LEN_W'(r_m) == (r_len - LEN_W'(1)));

    always_comb begin
        case (r_k)
            2'd0:    fetch_idx = r_m - MI_W'(2);
            2'd1:    fetch_idx = r_m - MI_W'(1);
            2'd2:    fetch_idx = r_m;
            default: fetch_idx = last_pt ? (r_m - MI_W'(2)) : (r_m + MI_W'(1));
        endcase
    end

    // At the last point the fourth tap re-reads point m-2, which gives
    // h3 = -(h1+h2) and f4 = f1 from the ordinary formulas.
    always_comb begin
        case (r_j)
            3'd0:    load_val = udiff(r_tap[1], r_tap[0]);
            3'd1:    load_val = udiff(r_tap[2], r_tap[1]);
            3'd2:    load_val = udiff(r_tap[3], r_tap[2]);
            3'd3:    load_val = udiff(r_rq, r_tap[1]);
            default: load_val = udiff(r_rq, r_tap[2]);
        endcase
    end

    assign rad_ra  = RA_W'(int'(r_sp) * MESH_MAX + int'(rd_idx));
    assign wave_ra = WA_W'(((int'(r_sp) * ANG_MAX + int'(r_ang)) * MUL_MAX + int'(r_mul))
                           * MESH_MAX + int'(rd_idx));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && cmd == CMD_QUERY) n_state = short_mesh ? S_OUT : S_A0;
            end
            S_A0:     n_state = S_A1;
            S_A1:     n_state = (r_rq < r_rad_rd) ? S_OUT : S_A2;
            S_A2:     n_state = (r_rad_rd < r_rq) ? S_OUT : S_SRCH;
            S_SRCH:   n_state = ((r_hi - r_lo) == MI_W'(1)) ? S_FADDR : S_SCMP;
            S_SCMP:   n_state = S_SRCH;
            S_FADDR:  n_state = S_FCAPT;
            S_FCAPT:  n_state = (r_k == 2'd3) ? S_LOAD : S_FADDR;
            S_LOAD:   n_state = (r_j == 3'd4) ? S_EXRD : S_LOAD;
            S_EXRD:   n_state = S_EXGO;
            S_EXGO:   n_state = S_EXWAIT;
            S_EXWAIT: begin
                if (alu_rsp.done) begin
                    n_state = (r_pc == PC_W'(PROG_LEN - 1)) ? S_OUT : S_EXRD;
                end
            end
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready       = 1'b0;
        rd_idx        = '0;
        rf_we         = 1'b0;
        rf_wa         = step.dst;
        rf_wd         = alu_rsp.value;
        alu_req.start = 1'b0;
        alu_req.op    = step.op;
        unique case (r_state)
            S_IDLE:   o_ready = 1'b1;
            S_A1:     rd_idx = MI_W'(r_len - LEN_W'(1));
            S_SRCH:   rd_idx = mid;
            S_FADDR:  rd_idx = fetch_idx;
            S_FCAPT: begin
                rf_we = 1'b1;
                rf_wa = RF_F1 + {2'b0, r_k};
                rf_wd = sq_q32(r_wave_rd);
            end
            S_LOAD: begin
                rf_we = 1'b1;
                rf_wa = RF_H1 + {1'b0, r_j};
                rf_wd = load_val;
            end
            S_EXGO:   alu_req.start = 1'b1;
            S_EXWAIT: rf_we = alu_rsp.done;
            default:  ;
        endcase
    end

    assign o_valid   = r_out_valid;
    assign o_density = r_out_dens;
    assign o_region  = r_out_region;

    // output register: fill from the finished query, drain on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dens   <= r_dens;
            r_out_region <= r_region;
        end
    end

    // table and scratch memories, read data registered
    always_ff @(posedge i_clk) begin
        if (rad_we) rad_mem[rad_wa] <= i_table_value;
        r_rad_rd <= rad_mem[rad_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wave_we) wave_mem[wave_wa] <= i_table_value;
        r_wave_rd <= wave_mem[wave_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) rf_mem[rf_wa] <= rf_wd;
        r_rf_a <= rf_mem[step.src_a];
        r_rf_b <= rf_mem[step.src_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SPECIES; i++) r_lengths[i] <= '0;
        end else if (len_we) begin
            r_lengths[SP_W'(i_species)] <= len_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD) r_pc <= '0;
            if (r_state == S_EXWAIT && alu_rsp.done) r_pc <= r_pc + PC_W'(1);
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    r_sp     <= i_species;
                    r_ang    <= i_ang_index;
                    r_mul    <= i_multiplicity;
                    r_rq     <= i_radius;
                    r_len    <= len_sel;
                    r_dens   <= '0;
                    r_region <= RGN_SHORT;
                end
            end
            S_A1: begin
                // below the first point: squared first value for angular index 0
                if (r_rq < r_rad_rd) begin
                    r_region <= RGN_BELOW;
                    r_dens   <= (r_ang == 2'd0) ? clamp48(sq_q32(r_wave_rd)) : '0;
                end
            end
            S_A2: begin
                if (r_rad_rd < r_rq) begin
                    r_region <= RGN_BEYOND;
                    r_dens   <= '0;
                end
                r_lo <= '0;
                r_hi <= MI_W'(r_len - LEN_W'(1));
            end
            S_SRCH: begin
                r_mid <= mid;
                r_m   <= (r_hi < MI_W'(2)) ? MI_W'(2) : r_hi;
                r_k   <= '0;
            end
            S_SCMP: begin
                if (r_rad_rd < r_rq) r_lo <= r_mid;
                else r_hi <= r_mid;
            end
            S_FCAPT: begin
                r_tap[r_k] <= r_rad_rd;
                r_k        <= r_k + 2'd1;
                r_j        <= '0;
            end
            S_LOAD: begin
                r_j <= r_j + 3'd1;
            end
            S_EXWAIT: begin
                if (alu_rsp.done && r_pc == PC_W'(PROG_LEN - 1)) begin
                    r_dens   <= clamp48(alu_rsp.value);
                    r_region <= RGN_INSIDE;
                end
            end
            default: ;
        endcase
    end

    rdsl_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_rf_a),
        .i_b     (r_rf_b),
        .o_rsp   (alu_rsp)
    );

endmodule
`default_nettype wire

// File: rtl/core/rdsl_checker.sv
// Port-level checker of the radial density spline lookup and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rdsl_checker
    import rdsl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [47:0] o_density,
    input logic [1:0]         o_region
);

    `RDSL_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_density) && $stable(o_region), "result changed while stalled")
    `RDSL_ASSERT(a_known, i_clk, i_rst_n, !$isunknown(o_ready) && !$isunknown(o_valid), "handshake outputs unknown")
    `RDSL_ASSERT(a_zero_out, i_clk, i_rst_n, o_valid && (o_region == RGN_BEYOND || o_region == RGN_SHORT) |-> o_density == 48'sd0, "nonzero density outside the mesh")
    `RDSL_ASSERT(a_below_pos, i_clk, i_rst_n, o_valid && o_region == RGN_BELOW |-> !o_density[47], "negative density below the mesh")
    `RDSL_ASSERT_NR(a_reset, i_clk, !i_rst_n |=> !o_valid && o_ready, "unit not idle after reset")

endmodule

bind radial_density_spline_lookup_unit rdsl_checker u_rdsl_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_density (o_density),
    .o_region  (o_region)
);
`default_nettype wire
